// ===== hw/rtl/scts_pkg.sv =====
// package for the sorted code table search core
// payload structs, item kind codes and letter helper functions
// no dependencies
`timescale 1ns / 1ps

package scts_pkg;

  localparam int MAX_ENTRIES_DEF = 4096;
  localparam int ALPHA           = 26;
  localparam int CODE_LEN        = 3;
  localparam logic [7:0] LETTER_A = 8'h41;

  localparam logic [2:0] KIND_LOAD   = 3'd0;
  localparam logic [2:0] KIND_EXACT  = 3'd1;
  localparam logic [2:0] KIND_PREFIX = 3'd2;
  localparam logic [2:0] KIND_SPIN   = 3'd3;
  localparam logic [2:0] KIND_REPAIR = 3'd4;
  localparam logic [2:0] KIND_FIRST  = 3'd5;

  typedef enum logic [1:0] {
    ORD_EQ,
    ORD_LT,
    ORD_GT
  } ord_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] entry_index;
    logic [7:0]  letter_a;
    logic [7:0]  letter_b;
    logic [7:0]  letter_c;
    logic [1:0]  prefix_length;
    logic [1:0]  position;
    logic        direction;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [11:0] match_index;
    logic [7:0]  out_letter_a;
    logic [7:0]  out_letter_b;
    logic [7:0]  out_letter_c;
  } rsp_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  // (c - 'A') mod 26 via reciprocal multiply, undershoot fixed by one subtract
  function automatic logic [4:0] alpha_place(input logic [7:0] c);
    logic [8:0]  x;
    logic [15:0] prod;
    logic [4:0]  q;
    logic [8:0]  r;
    x    = 9'(c) + 9'd195;
    prod = 16'(x) * 16'd78;
    q    = 5'(prod >> 11);
    r    = x - 9'(q) * 9'd26;
    if (r >= 9'd26) begin
      r = r - 9'd26;
    end
    return 5'(r);
  endfunction

  function automatic logic [4:0] place_step(input logic [4:0] p, input logic back);
    logic [4:0] r;
    if (back) begin
      r = (p == 5'd0) ? 5'(ALPHA - 1) : p - 5'd1;
    end else begin
      r = (p == 5'(ALPHA - 1)) ? 5'd0 : p + 5'd1;
    end
    return r;
  endfunction

  function automatic logic [7:0] place_letter(input logic [4:0] p);
    return LETTER_A + 8'(p);
  endfunction

  // order of a stored code against the first len typed letters
  function automatic ord_e order_of(input logic [23:0] e, input logic [2:0][7:0] p,
                                    input logic [1:0] len);
    ord_e       r;
    logic       done;
    logic [7:0] t;
    logic [7:0] l;
    r    = ORD_EQ;
    done = 1'b0;
    for (int k = 0; k < CODE_LEN; k++) begin
      t = upcase(p[2-k]);
      l = e[23-8*k -: 8];
      if (!done && k < int'(len) && l != t) begin
        r    = (l < t) ? ORD_LT : ORD_GT;
        done = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/sorted_code_table_search_core.sv =====
// top level of the sorted code table search core: sequencer around the table ram
// depends on scts_pkg and scts_mem
//
//  channel | handshake                      | payload
//  item    | start, busy                    | req_i  (scts_pkg::req_t)
//  result  | done_o (one-cycle strobe)      | rsp_o  (scts_pkg::rsp_t)
//  config  | cfg_valid_i, cfg_ready_o       | cfg_data_i (entry count)
//
// a load, unused kind, short exact lookup, spin at position 3 or first-with-prefix with
// empty prefix answers in the cycle after the beat; exact and prefix lookups, spin and
// repair run bisections, each probe a read then a compare through the single ram port
// spin chains up to 26 bisections, repair up to 27 per letter plus a read of slot zero
// in S_FBRD and S_FB, first-with-prefix scans one entry at a time; busy is high while
// an item runs and is low again in the strobe cycle
// reset clears control state only, the table is undefined until loaded
// the result cannot be stalled; rsp_o holds it from the strobe until the next item is taken
module sorted_code_table_search_core #(
  parameter int MAX_ENTRIES = scts_pkg::MAX_ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  scts_pkg::req_t req_i,
  output logic           done_o,
  output scts_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [12:0]    cfg_data_i
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BIS  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_SCMP = 3'd5;
  localparam logic [2:0] S_FBRD = 3'd6;
  localparam logic [2:0] S_FB   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [12:0]      cnt_q, cnt_d;
  logic [CW-1:0]    n_q, n_d;
  logic [CW-1:0]    low_q, low_d, high_q, high_d, mid_q, mid_d, mid_c;
  logic [1:0]       blen_q, blen_d;
  logic             bhit_q, bhit_d;
  logic [CW-1:0]    bwhere_q, bwhere_d;
  logic [2:0]       kind_q, kind_d;
  logic [2:0][7:0]  cur_q, cur_d, orig_q, orig_d;
  logic [1:0]       pos_q, pos_d;
  logic             back_q, back_d;
  logic [4:0]       place_q, place_d, tried_q, tried_d;
  logic             trying_q, trying_d;
  logic             done_q, done_d;
  scts_pkg::rsp_t   rsp_q, rsp_d;

  logic             accept;
  logic             mem_en, mem_we;
  logic [AW-1:0]    mem_addr;
  logic [23:0]      mem_rdata;
  scts_pkg::ord_e   ord;
  logic [2:0][7:0]  in_let;
  logic [4:0]       p0;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign in_let      = {req_i.letter_a, req_i.letter_b, req_i.letter_c};
  assign mid_c       = low_q + ((high_q - low_q) >> 1);
  assign ord         = scts_pkg::order_of(mem_rdata, cur_q, blen_q);
  assign p0          = scts_pkg::place_step(scts_pkg::alpha_place(in_let[2-req_i.position[0+:2]]),
                                            req_i.direction);

  scts_mem #(
    .DEPTH(MAX_ENTRIES),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i({req_i.letter_a, req_i.letter_b, req_i.letter_c}),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    low_d    = low_q;
    high_d   = high_q;
    mid_d    = mid_q;
    blen_d   = blen_q;
    bhit_d   = bhit_q;
    bwhere_d = bwhere_q;
    kind_d   = kind_q;
    cur_d    = cur_q;
    orig_d   = orig_q;
    pos_d    = pos_q;
    back_d   = back_q;
    place_d  = place_q;
    tried_d  = tried_q;
    trying_d = trying_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = AW'(mid_c);

    if (cfg_valid_i && cfg_ready_o) begin
      cnt_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d = req_i.kind;
          cur_d  = in_let;
          orig_d = in_let;
          pos_d  = req_i.position;
          back_d = req_i.direction;
          // a count written in the same cycle applies to this item
          n_d    = (18'(cnt_d) > 18'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cnt_d);
          low_d  = '0;
          high_d = n_d;
          rsp_d  = '0;
          case (req_i.kind)
            scts_pkg::KIND_LOAD: begin
              done_d = 1'b1;
              if (17'(req_i.entry_index) < 17'(MAX_ENTRIES)) begin
                mem_en      = 1'b1;
                mem_we      = 1'b1;
                mem_addr    = AW'(req_i.entry_index);
                rsp_d.found = 1'b1;
              end
            end
            scts_pkg::KIND_EXACT: begin
              if (req_i.prefix_length == 2'd3) begin
                blen_d  = 2'd3;
                state_d = S_BIS;
              end else begin
                done_d = 1'b1;
              end
            end
            scts_pkg::KIND_PREFIX: begin
              blen_d  = req_i.prefix_length;
              state_d = S_BIS;
            end
            scts_pkg::KIND_SPIN: begin
              if (req_i.position == 2'd3) begin
                rsp_d.out_letter_a = req_i.letter_a;
                rsp_d.out_letter_b = req_i.letter_b;
                rsp_d.out_letter_c = req_i.letter_c;
                done_d = 1'b1;
              end else begin
                place_d = p0;
                cur_d[2-req_i.position] = scts_pkg::place_letter(p0);
                tried_d = '0;
                blen_d  = req_i.position + 2'd1;
                state_d = S_BIS;
              end
            end
            scts_pkg::KIND_REPAIR: begin
              pos_d    = 2'd0;
              trying_d = 1'b0;
              blen_d   = 2'd1;
              state_d  = S_BIS;
            end
            scts_pkg::KIND_FIRST: begin
              if (req_i.prefix_length == 2'd0) begin
                done_d = 1'b1;
              end else begin
                blen_d  = req_i.prefix_length;
                mid_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_BIS: begin
        bwhere_d = '0;
        if (blen_q == 2'd0) begin
          bhit_d  = (n_q != '0);
          state_d = S_EVAL;
        end else if (low_q < high_q) begin
          mem_en   = 1'b1;
          mem_addr = AW'(mid_c);
          mid_d    = mid_c;
          state_d  = S_CMP;
        end else begin
          bhit_d  = 1'b0;
          state_d = S_EVAL;
        end
      end
      S_CMP: begin
        case (ord)
          scts_pkg::ORD_EQ: begin
            bhit_d   = 1'b1;
            bwhere_d = mid_q;
            state_d  = S_EVAL;
          end
          scts_pkg::ORD_LT: begin
            low_d   = mid_q + CW'(1);
            state_d = S_BIS;
          end
          default: begin
            high_d  = mid_q;
            state_d = S_BIS;
          end
        endcase
      end
      S_EVAL: begin
        // next bisection, if any, restarts over the whole live range
        low_d  = '0;
        high_d = n_q;
        case (kind_q)
          scts_pkg::KIND_EXACT: begin
            rsp_d.found       = bhit_q;
            rsp_d.match_index = bhit_q ? 12'(bwhere_q) : 12'd0;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          scts_pkg::KIND_SPIN: begin
            if (bhit_q) begin
              rsp_d.found = 1'b1;
              {rsp_d.out_letter_a, rsp_d.out_letter_b, rsp_d.out_letter_c} = cur_q;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (tried_q == 5'(scts_pkg::ALPHA - 1)) begin
              {rsp_d.out_letter_a, rsp_d.out_letter_b, rsp_d.out_letter_c} = orig_q;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              tried_d = tried_q + 5'd1;
              place_d = scts_pkg::place_step(place_q, back_q);
              cur_d[2-pos_q] = scts_pkg::place_letter(place_d);
              state_d = S_BIS;
            end
          end
          scts_pkg::KIND_REPAIR: begin
            if (bhit_q) begin
              if (pos_q == 2'd2) begin
                rsp_d.found = 1'b1;
                {rsp_d.out_letter_a, rsp_d.out_letter_b, rsp_d.out_letter_c} = cur_q;
                done_d  = 1'b1;
                state_d = S_IDLE;
              end else begin
                pos_d    = pos_q + 2'd1;
                blen_d   = pos_q + 2'd2;
                trying_d = 1'b0;
                state_d  = S_BIS;
              end
            end else if (!trying_q) begin
              trying_d = 1'b1;
              tried_d  = '0;
              place_d  = scts_pkg::alpha_place(cur_q[2-pos_q]);
              cur_d[2-pos_q] = scts_pkg::place_letter(place_d);
              state_d  = S_BIS;
            end else if (tried_q == 5'(scts_pkg::ALPHA - 1)) begin
              // no letter continues here: fall back to slot zero, or finish if the table is empty
              state_d = (n_q != '0) ? S_FBRD : S_IDLE;
              done_d  = (n_q == '0);
            end else begin
              tried_d = tried_q + 5'd1;
              place_d = scts_pkg::place_step(place_q, 1'b0);
              cur_d[2-pos_q] = scts_pkg::place_letter(place_d);
              state_d = S_BIS;
            end
          end
          default: begin
            rsp_d.found = bhit_q;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (mid_q < n_q) begin
          mem_en   = 1'b1;
          mem_addr = AW'(mid_q);
          state_d  = S_SCMP;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SCMP: begin
        if (ord == scts_pkg::ORD_EQ) begin
          rsp_d.found       = 1'b1;
          rsp_d.match_index = 12'(mid_q);
          {rsp_d.out_letter_a, rsp_d.out_letter_b, rsp_d.out_letter_c} = mem_rdata;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          mid_d   = mid_q + CW'(1);
          state_d = S_SCAN;
        end
      end
      S_FBRD: begin
        mem_en   = 1'b1;
        mem_addr = '0;
        state_d  = S_FB;
      end
      S_FB: begin
        {rsp_d.out_letter_a, rsp_d.out_letter_b, rsp_d.out_letter_c} = mem_rdata;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    low_q    <= low_d;
    high_q   <= high_d;
    mid_q    <= mid_d;
    blen_q   <= blen_d;
    bhit_q   <= bhit_d;
    bwhere_q <= bwhere_d;
    kind_q   <= kind_d;
    cur_q    <= cur_d;
    orig_q   <= orig_d;
    pos_q    <= pos_d;
    back_q   <= back_d;
    place_q  <= place_d;
    tried_q  <= tried_d;
    trying_q <= trying_d;
    rsp_q    <= rsp_d;
  end

endmodule

// ===== hw/rtl/scts_mem.sv =====
// code table storage: single port synchronous ram with a registered read port
// depends on nothing but its parameters
`timescale 1ns / 1ps

module scts_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [23:0]   wdata_i,
  output logic [23:0]   rdata_o
);

  logic [23:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

// ===== hw/rtl/scts_checker.sv =====
// port-level checks for the sorted code table search core, bound to the top level
// depends on scts_pkg and sorted_code_table_search_core
`timescale 1ns / 1ps

module scts_port_checks (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           done_o,
  input scts_pkg::rsp_t rsp_o,
  input logic           cfg_ready_o
);

  // every result strobe closes an item that was running or just taken
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_o) || $past(start_i)))
    else $error("result strobe without an item in flight");

  // an accepted beat is either answered next cycle or still being worked on
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (done_o || busy_o))
    else $error("accepted item vanished");

  a_index_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.found) |-> (rsp_o.match_index == 12'd0))
    else $error("match index without a match");

  a_no_cfg_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cfg_ready_o)
    else $error("config accepted mid item");

endmodule

bind sorted_code_table_search_core scts_port_checks u_scts_port_checks (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start),
  .busy_o     (busy),
  .done_o     (done_o),
  .rsp_o      (rsp_o),
  .cfg_ready_o(cfg_ready_o)
);
